// ===== rtl/fdl_pkg.sv =====
// ----------------------------------------------------------------------------
// fdl_pkg: shared types and constants of the feedback delay line
// Register indexes, gain format and the stage enables of the mix datapath.
// ----------------------------------------------------------------------------
package fdl_pkg;

	// Gain format: 8-bit unsigned, value/255
	localparam int GAIN_BITS = 8;

	// Width of the delay length register
	localparam int LEN_BITS = 17;

	// Configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = LEN_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DELAY_LENGTH  = 3'd0,
		REG_DRY_GAIN      = 3'd1,
		REG_WET_GAIN      = 3'd2,
		REG_STORE_GAIN    = 3'd3,
		REG_FEEDBACK_GAIN = 3'd4
	} cfg_reg_t;

	// Reset values of the registers
	localparam logic [LEN_BITS-1:0]  RST_DELAY_LENGTH  = 17'd1;
	localparam logic [GAIN_BITS-1:0] RST_DRY_GAIN      = 8'd255;
	localparam logic [GAIN_BITS-1:0] RST_WET_GAIN      = 8'd0;
	localparam logic [GAIN_BITS-1:0] RST_STORE_GAIN    = 8'd0;
	localparam logic [GAIN_BITS-1:0] RST_FEEDBACK_GAIN = 8'd0;

	// Load enables of the mix pipeline registers
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// ===== rtl/fdl_in_if.sv =====
// ----------------------------------------------------------------------------
// fdl_in_if: input sample channel
// Valid/ready channel carrying one audio sample and its block-end flag.
// ----------------------------------------------------------------------------
interface fdl_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_end;

	modport source (output valid, output sample_in, output block_end, input ready);
	modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

// ===== rtl/fdl_out_if.sv =====
// ----------------------------------------------------------------------------
// fdl_out_if: output sample channel
// Valid/ready channel carrying one mixed sample and its block-end flag.
// ----------------------------------------------------------------------------
interface fdl_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          block_end_out;

	modport source (output valid, output sample_out, output block_end_out, input ready);
	modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

// ===== rtl/fdl_ram.sv =====
// ----------------------------------------------------------------------------
// fdl_ram: generic single-clock RAM
// One write port, one read port, registered read data. A read of the entry
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module fdl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while no read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/fdl_mix.sv =====
// ----------------------------------------------------------------------------
// fdl_mix: weighted sum of two samples, divided by 255 and saturated
// Computes sat(round((a*ga + b*gb)/255)) over four register stages:
// products, sum, rounded magnitude, quotient estimate. The last step
// corrects the estimate and saturates without a register at its end.
// ----------------------------------------------------------------------------
module fdl_mix #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  fdl_pkg::stage_en_t                    en,
	input  logic signed [SAMPLE_BITS-1:0]         a,
	input  logic [fdl_pkg::GAIN_BITS-1:0]         ga,
	input  logic signed [SAMPLE_BITS-1:0]         b,
	input  logic [fdl_pkg::GAIN_BITS-1:0]         gb,
	output logic signed [SAMPLE_BITS-1:0]         q
);

	localparam int GB   = fdl_pkg::GAIN_BITS;
	localparam int DIV  = (1 << GB) - 1;          // 255
	localparam int HALF = DIV / 2;                // 127, round to nearest
	localparam int PW   = SAMPLE_BITS + GB + 1;   // product
	localparam int SW   = PW + 1;                 // sum of two products
	localparam int MW   = SAMPLE_BITS + GB;       // rounded magnitude
	localparam int NT   = (MW - 1) / GB;          // terms of the 1/255 series
	localparam int QW   = SAMPLE_BITS + 2;        // quotient
	localparam int RW   = $clog2(DIV * (NT + 1)); // remainder
	localparam int CNTW = $clog2(NT + 1);

	localparam logic [QW-1:0] LIM = QW'(1) << (SAMPLE_BITS - 1);

	logic signed [PW-1:0] pa_s2, pb_s2;
	logic signed [SW-1:0] sum_s3;
	logic [MW-1:0]        m_s4, m_s5;
	logic                 neg_s4, neg_s5;
	logic [QW-1:0]        qa_s5;

	logic signed [SW-1:0] m_full;
	logic [QW-1:0]        qa_c;
	logic [RW-1:0]        r_c;
	logic [CNTW-1:0]      cnt_c;
	logic [QW-1:0]        q_c;
	logic [QW-1:0]        qn_c;

	// stage 2: products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pa_s2 <= $signed(a) * $signed({1'b0, ga});
			pb_s2 <= $signed(b) * $signed({1'b0, gb});
		end
	end

	// stage 3: weighted sum
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3 <= SW'(pa_s2) + SW'(pb_s2);
		end
	end

	// |sum| + 127 in one add
	always_comb begin
		if (sum_s3[SW-1]) begin
			m_full = SW'(HALF) - sum_s3;
		end else begin
			m_full = sum_s3 + SW'(HALF);
		end
	end

	// stage 4: rounded magnitude and sign
	always_ff @(posedge clk) begin
		if (en.s4) begin
			m_s4   <= MW'(unsigned'(m_full));
			neg_s4 <= sum_s3[SW-1];
		end
	end

	// m/255 estimate: m/256 + m/65536 + ..., low by at most NT
	always_comb begin
		qa_c = '0;
		for (int k = 1; k <= NT; k++) begin
			qa_c = qa_c + QW'(m_s4 >> (GB * k));
		end
	end

	// stage 5: estimate
	always_ff @(posedge clk) begin
		if (en.s5) begin
			qa_s5  <= qa_c;
			m_s5   <= m_s4;
			neg_s5 <= neg_s4;
		end
	end

	// remainder m - 255*qa is small, so only its low bits are needed
	always_comb begin
		r_c   = RW'(m_s5) - RW'(qa_s5 << GB) + RW'(qa_s5);
		cnt_c = '0;
		for (int j = 1; j <= NT; j++) begin
			if (r_c >= RW'(j * DIV)) begin
				cnt_c = cnt_c + CNTW'(1);
			end
		end
		q_c  = qa_s5 + QW'(cnt_c);
		qn_c = ~q_c + QW'(1);
	end

	// apply sign and saturate
	always_comb begin
		if (neg_s5) begin
			if (q_c > LIM) begin
				q = SAMPLE_BITS'(LIM);
			end else begin
				q = SAMPLE_BITS'(qn_c);
			end
		end else begin
			if (q_c >= LIM) begin
				q = SAMPLE_BITS'(LIM - QW'(1));
			end else begin
				q = SAMPLE_BITS'(q_c);
			end
		end
	end

endmodule

// ===== rtl/feedback_delay_line_top.sv =====
// ----------------------------------------------------------------------------
// feedback_delay_line_top: echo effect with a circular feedback delay memory
// Each sample outputs in*dry + delayed*wet and writes in*store +
// delayed*feedback back to its delay slot, gains in units of 1/255.
// ----------------------------------------------------------------------------
// Throughput is one sample per clock while the effective delay length is
// six or more and the output is not stalled; the delay memory is read when
// a sample is taken and written back as the sample leaves stage 5, so a
// sample whose slot is still held by an earlier sample in the pipeline
// waits, and a delay length L below six lowers the rate. After reset the
// block clears every entry of the delay memory, one entry per cycle, and
// takes no sample in that time; register writes are taken throughout. The
// user must write registers only while idle; the block does not enforce it.
module feedback_delay_line_top #(
	parameter int MAX_DELAY   = 65536,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	fdl_in_if.sink                                sample_ch,
	fdl_out_if.source                             result_ch,
	input  logic                                  cfg_we,
	input  logic [fdl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [fdl_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

	localparam int GB  = fdl_pkg::GAIN_BITS;
	localparam int AW  = $clog2(MAX_DELAY);
	localparam int LW  = $clog2(MAX_DELAY + 1);
	localparam int CW  = (LW > fdl_pkg::LEN_BITS) ? LW : fdl_pkg::LEN_BITS;

	// configuration registers
	logic [fdl_pkg::LEN_BITS-1:0] delay_length_q;
	logic [GB-1:0]                dry_gain_q, wet_gain_q, store_gain_q, feedback_gain_q;

	// position and clearing pass
	logic [AW-1:0] pos_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// pipeline control and payload
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0]                 addr_s1, addr_s2, addr_s3, addr_s4, addr_s5;
	logic                          be_s1, be_s2, be_s3, be_s4, be_s5;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          out_v_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_be_q;

	logic                          en1, en6;
	fdl_pkg::stage_en_t            en_mix;
	logic                          hazard;
	logic                          accept;
	logic [CW-1:0]                 len_eff;
	logic [CW-1:0]                 pos_nxt;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [SAMPLE_BITS-1:0]        ram_wdata;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic signed [SAMPLE_BITS-1:0] y_mix, w_mix;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q  <= fdl_pkg::RST_DELAY_LENGTH;
			dry_gain_q      <= fdl_pkg::RST_DRY_GAIN;
			wet_gain_q      <= fdl_pkg::RST_WET_GAIN;
			store_gain_q    <= fdl_pkg::RST_STORE_GAIN;
			feedback_gain_q <= fdl_pkg::RST_FEEDBACK_GAIN;
		end else if (cfg_we) begin
			unique case (fdl_pkg::cfg_reg_t'(cfg_index))
				fdl_pkg::REG_DELAY_LENGTH:  delay_length_q  <= cfg_wdata;
				fdl_pkg::REG_DRY_GAIN:      dry_gain_q      <= cfg_wdata[GB-1:0];
				fdl_pkg::REG_WET_GAIN:      wet_gain_q      <= cfg_wdata[GB-1:0];
				fdl_pkg::REG_STORE_GAIN:    store_gain_q    <= cfg_wdata[GB-1:0];
				fdl_pkg::REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_wdata[GB-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its item moves on
	always_comb begin
		en6       = !out_v_q || result_ch.ready;
		en_mix.s5 = !v_s5 || en6;
		en_mix.s4 = !v_s4 || en_mix.s5;
		en_mix.s3 = !v_s3 || en_mix.s4;
		en_mix.s2 = !v_s2 || en_mix.s3;
		en1       = !v_s1 || en_mix.s2;
	end

	// interlock: slot still in flight, not yet written back
	always_comb begin
		hazard = (v_s1 && addr_s1 == pos_q) || (v_s2 && addr_s2 == pos_q) ||
		         (v_s3 && addr_s3 == pos_q) || (v_s4 && addr_s4 == pos_q) ||
		         (v_s5 && addr_s5 == pos_q);
	end

	assign sample_ch.ready = !clr_q && en1 && !hazard;
	assign accept          = sample_ch.valid && sample_ch.ready;

	// effective length and next position
	always_comb begin
		len_eff = CW'(delay_length_q);
		if (len_eff == '0) begin
			len_eff = CW'(1);
		end else if (len_eff > CW'(MAX_DELAY)) begin
			len_eff = CW'(MAX_DELAY);
		end
		pos_nxt = CW'(pos_q) + CW'(1);
		if (pos_nxt >= len_eff) begin
			pos_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_nxt[AW-1:0];
		end
	end

	// clearing pass over the delay memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(MAX_DELAY - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)       v_s1    <= accept;
			if (en_mix.s2) v_s2    <= v_s1;
			if (en_mix.s3) v_s3    <= v_s2;
			if (en_mix.s4) v_s4    <= v_s3;
			if (en_mix.s5) v_s5    <= v_s4;
			if (en6)       out_v_q <= v_s5;
		end
	end

	// pipeline payload: slot address, flag, input sample, output register
	always_ff @(posedge clk) begin
		if (en1) begin
			addr_s1 <= pos_q;
			be_s1   <= sample_ch.block_end;
			x_s1    <= sample_ch.sample_in;
		end
		if (en_mix.s2) begin
			addr_s2 <= addr_s1;
			be_s2   <= be_s1;
		end
		if (en_mix.s3) begin
			addr_s3 <= addr_s2;
			be_s3   <= be_s2;
		end
		if (en_mix.s4) begin
			addr_s4 <= addr_s3;
			be_s4   <= be_s3;
		end
		if (en_mix.s5) begin
			addr_s5 <= addr_s4;
			be_s5   <= be_s4;
		end
		if (en6) begin
			out_sample_q <= y_mix;
			out_be_q     <= be_s5;
		end
	end

	// write back as the item leaves stage 5, or zero during clearing
	always_comb begin
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = v_s5 && en6;
			ram_waddr = addr_s5;
			ram_wdata = w_mix;
		end
	end

	fdl_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_DELAY)
	) u_delay_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// output mix: in*dry + delayed*wet
	fdl_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix_out (
		.clk (clk),
		.en  (en_mix),
		.a   (x_s1),
		.ga  (dry_gain_q),
		.b   ($signed(ram_rdata)),
		.gb  (wet_gain_q),
		.q   (y_mix)
	);

	// write-back mix: in*store + delayed*feedback
	fdl_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix_fb (
		.clk (clk),
		.en  (en_mix),
		.a   (x_s1),
		.ga  (store_gain_q),
		.b   ($signed(ram_rdata)),
		.gb  (feedback_gain_q),
		.q   (w_mix)
	);

	assign result_ch.valid         = out_v_q;
	assign result_ch.sample_out    = out_sample_q;
	assign result_ch.block_end_out = out_be_q;

endmodule

// ===== tb/sv/tb_feedback_delay_line_top.sv =====
// ----------------------------------------------------------------------------
// tb_feedback_delay_line_top: self-checking bench for the feedback delay line
// Sends audio samples through the echo block under a series of delay and gain
// settings and checks every mixed sample against an in-bench echo predictor
// that keeps its own copy of the delay memory, position and registers.
// ----------------------------------------------------------------------------
module tb_feedback_delay_line_top;

	localparam int SAMPLE_BITS    = 16;
	localparam int MAX_DELAY      = 65536;
	localparam int ADDR_BITS      = $clog2(MAX_DELAY);
	localparam int LEN_BITS       = fdl_pkg::LEN_BITS;
	localparam int GAIN_BITS      = fdl_pkg::GAIN_BITS;
	localparam int CFG_INDEX_BITS = fdl_pkg::CFG_INDEX_BITS;
	localparam int CFG_DATA_BITS  = fdl_pkg::CFG_DATA_BITS;
	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int PIPE_LATENCY   = 6;
	localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
	localparam int TAIL_CYCLES    = 4 * PIPE_LATENCY;
	localparam int MAX_IDLE       = 19;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int REPORT_LIMIT   = 10;
	// the memory clear after reset is the longest stretch without a transaction
	localparam int WATCHDOG_LIMIT = 4 * (MAX_DELAY + 100);

	localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
	localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = SAMPLE_BITS'(SAMPLE_HI);
	localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = SAMPLE_BITS'(SAMPLE_LO);

	// register indexes with no register behind them
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO =
		CFG_INDEX_BITS'(fdl_pkg::REG_FEEDBACK_GAIN + 1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = '1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          block_end;
	} echo_sample_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata;

	fdl_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	fdl_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

	feedback_delay_line_top #(
		.MAX_DELAY   (MAX_DELAY),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// echo predictor state
	logic [LEN_BITS-1:0]           len_reg;
	logic [GAIN_BITS-1:0]          dry_reg;
	logic [GAIN_BITS-1:0]          wet_reg;
	logic [GAIN_BITS-1:0]          store_reg;
	logic [GAIN_BITS-1:0]          fb_reg;
	logic signed [SAMPLE_BITS-1:0] echo_mem [MAX_DELAY];
	logic [ADDR_BITS-1:0]          echo_pos;

	echo_sample_t pending_q [$];
	echo_sample_t expected_q [$];

	logic        src_busy;
	int unsigned src_gap;
	bit          src_calm;
	int unsigned sink_hold;
	bit          sink_calm;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	always #HALF_PERIOD clk = ~clk;

	// weighted sum of two samples, gains in 1/255, rounded to nearest, saturated
	function automatic logic signed [SAMPLE_BITS-1:0] scale_255(
		input logic signed [SAMPLE_BITS-1:0] a,
		input logic [GAIN_BITS-1:0]          ga,
		input logic signed [SAMPLE_BITS-1:0] b,
		input logic [GAIN_BITS-1:0]          gb
	);
		longint acc;
		longint quo;
		acc = longint'(a) * longint'(ga) + longint'(b) * longint'(gb);
		quo = ((acc < 0 ? -acc : acc) + 127) / 255;
		if (acc < 0)
			quo = -quo;
		if (quo > SAMPLE_HI)
			quo = SAMPLE_HI;
		if (quo < SAMPLE_LO)
			quo = SAMPLE_LO;
		return quo[SAMPLE_BITS-1:0];
	endfunction

	function automatic int unsigned draw_idle(input bit calm);
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic be);
		echo_sample_t it;
		it.sample    = s;
		it.block_end = be;
		pending_q.push_back(it);
	endtask

	// drive one register write; the predictor takes it now since the block is idle
	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input int unsigned data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_BITS'(data);
		case (idx)
			fdl_pkg::REG_DELAY_LENGTH:  len_reg   = data[LEN_BITS-1:0];
			fdl_pkg::REG_DRY_GAIN:      dry_reg   = data[GAIN_BITS-1:0];
			fdl_pkg::REG_WET_GAIN:      wet_reg   = data[GAIN_BITS-1:0];
			fdl_pkg::REG_STORE_GAIN:    store_reg = data[GAIN_BITS-1:0];
			fdl_pkg::REG_FEEDBACK_GAIN: fb_reg    = data[GAIN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic finish_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// nothing queued, nothing on the input, nothing outstanding
	task automatic wait_idle();
		while (pending_q.size() != 0 || src_busy || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sample source: gaps drawn per transaction, predicts on each accepted one
	always @(posedge clk or negedge arst_n) begin : sample_source
		echo_sample_t                  nxt;
		echo_sample_t                  predicted;
		logic signed [SAMPLE_BITS-1:0] delayed;
		int unsigned                   span;
		if (!arst_n) begin
			sample_ch.valid     <= 1'b0;
			sample_ch.sample_in <= '0;
			sample_ch.block_end <= 1'b0;
			src_busy = 1'b0;
			src_gap  = 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				if (len_reg == '0)
					span = 1;
				else if (len_reg > MAX_DELAY)
					span = MAX_DELAY;
				else
					span = 32'(len_reg);
				delayed = echo_mem[echo_pos];
				predicted.sample    = scale_255(sample_ch.sample_in, dry_reg,
					delayed, wet_reg);
				predicted.block_end = sample_ch.block_end;
				expected_q.push_back(predicted);
				echo_mem[echo_pos] = scale_255(sample_ch.sample_in, store_reg,
					delayed, fb_reg);
				// a shrunk length still uses the current slot, then wraps
				if (32'(echo_pos) + 1 >= span)
					echo_pos = '0;
				else
					echo_pos = echo_pos + 1'b1;
				src_busy = 1'b0;
				if ($urandom_range(0, 31) == 0)
					src_calm = !src_calm;
				src_gap = draw_idle(src_calm);
			end
			if (!src_busy) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (pending_q.size() != 0) begin
					nxt = pending_q.pop_front();
					sample_ch.sample_in <= nxt.sample;
					sample_ch.block_end <= nxt.block_end;
					src_busy = 1'b1;
				end
			end
			sample_ch.valid <= src_busy;
		end
	end

	// result sink: random stalls, compares each transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_sink
		echo_sample_t got;
		echo_sample_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			sink_hold = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got.sample    = result_ch.sample_out;
				got.block_end = result_ch.block_end_out;
				if (expected_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: unexpected result sample_out=%0d block_end_out=%0b",
							$realtime, got.sample, got.block_end);
				end else begin
					want = expected_q.pop_front();
					if (got.sample !== want.sample || got.block_end !== want.block_end) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display({"%0t: mismatch sample_out exp %0d got %0d,",
								" block_end_out exp %0b got %0b"},
								$realtime, want.sample, got.sample,
								want.block_end, got.block_end);
					end
				end
				if ($urandom_range(0, 31) == 0)
					sink_calm = !sink_calm;
				sink_hold = draw_idle(sink_calm);
			end
			if (sink_hold != 0) begin
				sink_hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_feedback_delay_line_top: FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		fdl_pkg::cfg_reg_t             gain_regs [4];
		int unsigned                   data;
		logic [GAIN_BITS-1:0]          gain;
		logic signed [SAMPLE_BITS-1:0] smp;
		int                            near_zero;
		int unsigned                   sent;
		int unsigned                   batch;

		// known values on every input from time zero
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.sample_in = '0;
		sample_ch.block_end = 1'b0;
		result_ch.ready     = 1'b0;
		src_busy            = 1'b0;
		src_gap             = 0;
		src_calm            = 1'b0;
		sink_hold           = 0;
		sink_calm           = 1'b0;
		mismatch_count      = 0;
		quiet_cycles        = 0;

		len_reg   = fdl_pkg::RST_DELAY_LENGTH;
		dry_reg   = fdl_pkg::RST_DRY_GAIN;
		wet_reg   = fdl_pkg::RST_WET_GAIN;
		store_reg = fdl_pkg::RST_STORE_GAIN;
		fb_reg    = fdl_pkg::RST_FEEDBACK_GAIN;
		foreach (echo_mem[i])
			echo_mem[i] = '0;
		echo_pos = '0;

		gain_regs[0] = fdl_pkg::REG_DRY_GAIN;
		gain_regs[1] = fdl_pkg::REG_WET_GAIN;
		gain_regs[2] = fdl_pkg::REG_STORE_GAIN;
		gain_regs[3] = fdl_pkg::REG_FEEDBACK_GAIN;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: straight pass-through of the extremes
		queue_sample(PEAK_POS, 1'b1);
		queue_sample(PEAK_NEG, 1'b0);
		queue_sample('0, 1'b1);
		queue_sample(SAMPLE_BITS'(-1), 1'b0);
		queue_sample(SAMPLE_BITS'(1), 1'b0);

		// zero length acts as one, full gains drive both sums into saturation;
		// a write to a spare index must change nothing
		wait_idle();
		write_register(fdl_pkg::REG_DELAY_LENGTH, '0);
		write_register(fdl_pkg::REG_DRY_GAIN, '1);
		write_register(fdl_pkg::REG_WET_GAIN, '1);
		write_register(fdl_pkg::REG_STORE_GAIN, '1);
		write_register(fdl_pkg::REG_FEEDBACK_GAIN, '1);
		write_register(REG_SPARE_LO, '0);
		write_register(REG_SPARE_HI, '0);
		finish_writes();
		queue_sample(PEAK_POS, 1'b0);
		queue_sample(PEAK_POS, 1'b1);
		queue_sample(PEAK_POS, 1'b0);
		queue_sample(PEAK_NEG, 1'b1);
		queue_sample(PEAK_NEG, 1'b0);
		queue_sample(PEAK_NEG, 1'b1);

		// length above the memory size clamps; uneven gains exercise rounding
		wait_idle();
		write_register(fdl_pkg::REG_DELAY_LENGTH, '1);
		write_register(fdl_pkg::REG_DRY_GAIN, 128);
		write_register(fdl_pkg::REG_WET_GAIN, 255);
		write_register(fdl_pkg::REG_STORE_GAIN, 1);
		write_register(fdl_pkg::REG_FEEDBACK_GAIN, 254);
		finish_writes();
		queue_sample(SAMPLE_BITS'(12345), 1'b0);
		queue_sample(SAMPLE_BITS'(-12345), 1'b1);
		queue_sample(PEAK_POS, 1'b0);
		queue_sample(PEAK_NEG, 1'b0);

		// length shrunk below the current position: slot used once, then wrap
		wait_idle();
		write_register(fdl_pkg::REG_DELAY_LENGTH, 2);
		write_register(fdl_pkg::REG_DRY_GAIN, 0);
		write_register(fdl_pkg::REG_STORE_GAIN, 255);
		write_register(fdl_pkg::REG_FEEDBACK_GAIN, 0);
		finish_writes();
		queue_sample(SAMPLE_BITS'(1000), 1'b0);
		queue_sample(SAMPLE_BITS'(2000), 1'b1);
		queue_sample(SAMPLE_BITS'(3000), 1'b0);

		// shortest length the block runs at full rate
		wait_idle();
		write_register(fdl_pkg::REG_DELAY_LENGTH, PIPE_LATENCY);
		write_register(fdl_pkg::REG_DRY_GAIN, 200);
		write_register(fdl_pkg::REG_WET_GAIN, 100);
		write_register(fdl_pkg::REG_STORE_GAIN, 77);
		write_register(fdl_pkg::REG_FEEDBACK_GAIN, 180);
		finish_writes();
		repeat (6)
			queue_sample(SAMPLE_BITS'($urandom), 1'(($urandom_range(0, 1))));

		// random settings, each followed by a batch of random samples
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: data = 0;
					1: data = MAX_DELAY;
					2: data = $urandom_range(MAX_DELAY + 1, (1 << LEN_BITS) - 1);
					3: data = 1;
					4: data = $urandom_range(2, PIPE_LATENCY - 1);
					5: data = PIPE_LATENCY;
					6: data = $urandom_range(65, 2000);
					default: data = $urandom_range(1, 64);
				endcase
				write_register(fdl_pkg::REG_DELAY_LENGTH, data);
			end
			foreach (gain_regs[g]) begin
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 3))
						0: gain = '0;
						1: gain = '1;
						default: gain = GAIN_BITS'($urandom);
					endcase
					// upper data bits are don't-care for a gain register
					data = $urandom;
					data[GAIN_BITS-1:0] = gain;
					write_register(gain_regs[g], data);
				end
			end
			if ($urandom_range(0, 3) == 0)
				write_register(CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					$urandom);
			finish_writes();

			batch = $urandom_range(20, 150);
			repeat (batch) begin
				case ($urandom_range(0, 7))
					0: smp = PEAK_POS;
					1: smp = PEAK_NEG;
					2: begin
						near_zero = int'($urandom_range(0, 64)) - 32;
						smp = near_zero[SAMPLE_BITS-1:0];
					end
					default: smp = SAMPLE_BITS'($urandom);
				endcase
				queue_sample(smp, 1'($urandom_range(0, 3) == 0));
			end
			sent += batch;
		end

		// drain and give the pipeline time to show any stray result
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0)
			$display("tb_feedback_delay_line_top: PASS");
		else
			$display("tb_feedback_delay_line_top: FAIL");
		$finish;
	end

endmodule
